// File: hw/rtl/rtcos_pkg.sv
// ============================================================================
// rtcos_pkg
// Shared types and constants for the round-trip clock offset block: word
// layouts of the request and response streams and the sequencer states.
// ============================================================================
`default_nettype none

package rtcos_pkg;

   // Request word kind, carried in tuser.
   localparam logic KIND_START = 1'b0;

   // Request tdata layout, lowest bit first.
   localparam int REQ_DATA_W      = 112;
   localparam int REQ_LOCAL_LSB   = 0;
   localparam int REQ_MY_LSB      = 32;
   localparam int REQ_REMOTE_LSB  = 48;
   localparam int REQ_ROUND_LSB   = 64;
   localparam int REQ_RXTIME_LSB  = 72;
   localparam int REQ_ADOPT_BIT   = 104;

   // Response tdata layout, lowest bit first.
   localparam int RSP_DATA_W      = 80;
   localparam int RSP_SEND_BIT    = 0;
   localparam int RSP_TIME_LSB    = 1;
   localparam int RSP_ROUND_LSB   = 33;
   localparam int RSP_ADOPT_BIT   = 41;
   localparam int RSP_DONE_BIT    = 42;
   localparam int RSP_UPD_BIT     = 43;
   localparam int RSP_OFFSET_LSB  = 44;
   localparam int RSP_BAD_BIT     = 76;

   // Starting value of the best interval in the minimum search.
   localparam logic [31:0] SPAN_ALL_ONES = 32'hFFFF_FFFF;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STAMP,
      ST_SCAN,
      ST_DRAIN,
      ST_PAIR,
      ST_APPLY,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/rtcos_ram.sv
// ============================================================================
// rtcos_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
`default_nettype none

module rtcos_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/round_trip_clock_offset_sync_top.sv
// Sequence: a start word or a bad round goes from EXEC to OUT after acceptance, a stamp word
// that sends a stamp passes through STAMP first; a stamp that completes the exchange with
// adopt set also walks the memory in SCAN, then goes through DRAIN, PAIR and APPLY to OUT.
// Throughput: one word at a time; the next word is taken in the cycle after the response is
// loaded, and for a completing word the walk over the memory, one read a cycle, adds to the wait.
// Reset clears the sequencer, round counter, adopt flag, offset and response valid only.
// ============================================================================
// round_trip_clock_offset_sync_top
// One side of a ping-pong timestamp exchange. Stamps are kept in a small
// RAM; on completion a sequencer walks the same-parity slots for the
// smallest two-round interval and moves the clock offset to the peer time.
// ============================================================================
`default_nettype none

module round_trip_clock_offset_sync_top
   import rtcos_pkg::*;
#(
   parameter int ROUNDS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // kind
   input  logic [REQ_DATA_W-1:0] req_tdata,   // local_time, my_sub_count, remote_sub_count,
                                              // rx_round, rx_time, rx_adopt, zero pad
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // send_stamp, stamp_time, stamp_round,
                                              // stamp_adopt, sync_done, offset_updated,
                                              // clock_offset, bad_round, zero pad
);

   localparam int AW = $clog2(ROUNDS);
   localparam int CW = $clog2(ROUNDS + 1);
   localparam int SW = $clog2(ROUNDS + 2);

   state_type state_ff, state_in;

   // Captured request word.
   logic          kind_ff;
   logic [31:0]   local_ff;
   logic [15:0]   my_ff;
   logic [15:0]   remote_ff;
   logic [7:0]    rx_round_ff;
   logic [31:0]   rx_time_ff;
   logic          rx_adopt_ff;

   // Exchange state.
   logic [CW-1:0] round_ff;
   logic          adopt_ff;
   logic [31:0]   offset_ff;

   // Result under construction.
   logic          send_ff;
   logic [31:0]   stamp_time_ff;
   logic [7:0]    stamp_round_ff;
   logic          stamp_adopt_ff;
   logic          done_ff;
   logic          upd_ff;
   logic          bad_ff;

   // Minimum search.
   logic [SW-1:0] scan_ff;
   logic          rd_vld_ff;
   logic [AW-1:0] rd_idx_ff;
   logic          first_ff;
   logic [31:0]   prev_ff;
   logic [31:0]   base_ff;
   logic [31:0]   best_ff;
   logic [AW-1:0] best_idx_ff;
   logic [31:0]   mid_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_word;

   // Memory port.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [31:0]   ram_rdata;

   // Derived values.
   logic [31:0]   adj_time;
   logic [CW-1:0] round_new;
   logic          round_bad;
   logic          round_send;
   logic          round_done;
   logic          stamp_done;
   logic          scan_last;
   logic [31:0]   span;
   logic          out_free;

   assign adj_time   = local_ff + offset_ff;
   assign round_bad  = (rx_round_ff >= 8'(ROUNDS));
   assign round_new  = CW'(rx_round_ff[AW-1:0]) + CW'(1);
   assign round_send = (round_new < CW'(ROUNDS));
   assign round_done = ((CW+1)'(round_new) + (CW+1)'(round_new[0])) >= (CW+1)'(ROUNDS);
   assign stamp_done = done_ff && adopt_ff;
   assign scan_last  = ((SW+1)'(scan_ff) + (SW+1)'(2)) >= (SW+1)'(ROUNDS);
   assign span       = ram_rdata - prev_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   rtcos_ram #(
      .WIDTH (32),
      .DEPTH (ROUNDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and memory control.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = '0;
      ram_raddr  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (kind_ff == KIND_START) begin
               ram_we    = 1'b1;
               ram_wdata = adj_time;
               state_in  = ST_OUT;
            end else if (round_bad) begin
               state_in = ST_OUT;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = rx_round_ff[AW-1:0];
               ram_wdata = rx_time_ff;
               if (round_send) begin
                  state_in = ST_STAMP;
               end else if (round_done && rx_adopt_ff) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_STAMP: begin
            ram_we    = 1'b1;
            ram_waddr = round_ff[AW-1:0];
            ram_wdata = adj_time;
            state_in  = stamp_done ? ST_SCAN : ST_OUT;
         end
         ST_SCAN: begin
            ram_raddr = scan_ff[AW-1:0];
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PAIR;
         end
         ST_PAIR: begin
            ram_raddr = best_idx_ff + AW'(1);
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Exchange state and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff     <= '0;
         adopt_ff     <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EXEC) begin
            if (kind_ff == KIND_START) begin
               round_ff <= '0;
               adopt_ff <= !(my_ff > remote_ff);
            end else if (!round_bad) begin
               round_ff <= round_new;
               adopt_ff <= rx_adopt_ff;
            end
         end
         // The pair read issued in ST_PAIR is now on the read data.
         if (state_ff == ST_APPLY) begin
            offset_ff <= offset_ff + (ram_rdata - mid_ff);
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response word assembled from the result fields.
   always_comb begin
      rsp_word                         = '0;
      rsp_word[RSP_SEND_BIT]           = send_ff;
      rsp_word[RSP_TIME_LSB +: 32]     = stamp_time_ff;
      rsp_word[RSP_ROUND_LSB +: 8]     = stamp_round_ff;
      rsp_word[RSP_ADOPT_BIT]          = stamp_adopt_ff;
      rsp_word[RSP_DONE_BIT]           = done_ff;
      rsp_word[RSP_UPD_BIT]            = upd_ff;
      rsp_word[RSP_OFFSET_LSB +: 32]   = offset_ff;
      rsp_word[RSP_BAD_BIT]            = bad_ff;
   end

   // Request capture and result fields.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         kind_ff     <= req_tuser;
         local_ff    <= req_tdata[REQ_LOCAL_LSB +: 32];
         my_ff       <= req_tdata[REQ_MY_LSB +: 16];
         remote_ff   <= req_tdata[REQ_REMOTE_LSB +: 16];
         rx_round_ff <= req_tdata[REQ_ROUND_LSB +: 8];
         rx_time_ff  <= req_tdata[REQ_RXTIME_LSB +: 32];
         rx_adopt_ff <= req_tdata[REQ_ADOPT_BIT];
      end
      if (state_ff == ST_EXEC) begin
         if (kind_ff == KIND_START) begin
            send_ff        <= 1'b1;
            stamp_time_ff  <= adj_time;
            stamp_round_ff <= '0;
            stamp_adopt_ff <= (my_ff > remote_ff);
            done_ff        <= 1'b0;
            upd_ff         <= 1'b0;
            bad_ff         <= 1'b0;
         end else if (round_bad) begin
            send_ff        <= 1'b0;
            stamp_time_ff  <= '0;
            stamp_round_ff <= '0;
            stamp_adopt_ff <= 1'b0;
            done_ff        <= 1'b0;
            upd_ff         <= 1'b0;
            bad_ff         <= 1'b1;
         end else begin
            send_ff        <= round_send;
            stamp_time_ff  <= round_send ? adj_time : '0;
            stamp_round_ff <= round_send ? 8'(round_new) : '0;
            stamp_adopt_ff <= round_send && !rx_adopt_ff;
            done_ff        <= round_done;
            upd_ff         <= round_done && rx_adopt_ff;
            bad_ff         <= 1'b0;
         end
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= rsp_word;
      end
   end

   // Minimum search over same-parity slots, one slot a cycle.
   always_ff @(posedge clock) begin
      rd_vld_ff <= (state_ff == ST_SCAN);
      // The walk starts at the first slot of the final round's parity.
      if (state_ff == ST_EXEC) begin
         scan_ff  <= SW'(round_new[0]);
         first_ff <= 1'b1;
      end
      if (state_ff == ST_SCAN) begin
         scan_ff   <= scan_ff + SW'(2);
         rd_idx_ff <= scan_ff[AW-1:0];
      end
      if (rd_vld_ff) begin
         prev_ff <= ram_rdata;
         if (first_ff) begin
            first_ff    <= 1'b0;
            base_ff     <= ram_rdata;
            best_ff     <= SPAN_ALL_ONES;
            best_idx_ff <= rd_idx_ff;
         end else if (span < best_ff) begin
            best_ff     <= span;
            best_idx_ff <= rd_idx_ff - AW'(2);
            base_ff     <= prev_ff;
         end
      end
      // Local midpoint of the chosen interval.
      if (state_ff == ST_PAIR) begin
         mid_ff <= base_ff + (best_ff >> 1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rtcos_checker.sv
// ============================================================================
// rtcos_checker
// Port-level checks on the round-trip clock offset block, bound to the top.
// ============================================================================
`default_nettype none

module rtcos_checker
   import rtcos_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic rsp_send;
   logic rsp_done;
   logic rsp_upd;
   logic rsp_bad;

   assign rsp_send = rsp_tdata[RSP_SEND_BIT];
   assign rsp_done = rsp_tdata[RSP_DONE_BIT];
   assign rsp_upd  = rsp_tdata[RSP_UPD_BIT];
   assign rsp_bad  = rsp_tdata[RSP_BAD_BIT];

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // An out-of-range round sends nothing and completes nothing.
   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_bad |-> !rsp_send && !rsp_done && !rsp_upd)
      else $error("bad round word with side effects");

   // The offset is only recomputed when the exchange completes.
   a_upd_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_upd |-> rsp_done)
      else $error("offset update without completion");

   // Stamp fields are zero when no stamp goes out.
   a_no_send_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_send |-> rsp_tdata[RSP_TIME_LSB +: 32] == 32'd0
         && rsp_tdata[RSP_ROUND_LSB +: 8] == 8'd0 && !rsp_tdata[RSP_ADOPT_BIT])
      else $error("stamp fields set on a word that sends nothing");

endmodule

bind round_trip_clock_offset_sync_top rtcos_checker u_rtcos_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/tb_round_trip_clock_offset_sync_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for round_trip_clock_offset_sync_top
// A driver feeds start and stamp words from a queue that is filled at time
// zero. Directed exchanges come first, then random exchanges with broken
// sequences and noise mixed in. Each accepted word is run through a
// behavioural predictor of the exchange, and a monitor checks every response
// word field by field against the oldest prediction. Both streams idle at
// random.
// ----------------------------------------------------------------------------

module tb_round_trip_clock_offset_sync_top;
   import rtcos_pkg::*;

   localparam int SLOTS        = 8;
   localparam int RANDOM_WORDS = 650;
   localparam int LIMIT_CYCLES = 400000;
   localparam int TAIL_CYCLES  = 32;
   localparam logic KIND_STAMP = ~KIND_START;

   // One request word as the block sees it.
   typedef struct packed {
      logic        kind;
      logic [31:0] local_time;
      logic [15:0] my_count;
      logic [15:0] remote_count;
      logic [7:0]  rx_round;
      logic [31:0] rx_time;
      logic        rx_adopt;
   } exch_word_type;

   // A queued word; drain makes the sender wait until all responses are in.
   typedef struct packed {
      exch_word_type w;
      bit            drain;
   } pending_word_type;

   // One response word.
   typedef struct packed {
      logic        send;
      logic [31:0] stamp_time;
      logic [7:0]  stamp_round;
      logic        stamp_adopt;
      logic        done;
      logic        updated;
      logic [31:0] offset;
      logic        bad;
   } sync_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = KIND_START;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   pending_word_type pending[$];
   sync_result_type  sync_expected[$];

   // Predictor state: stamp memory, round counter, adopt decision, offset.
   logic [31:0] ts_mem [SLOTS];
   logic [5:0]  rnd_cnt  = '0;
   logic        adopt_q  = 1'b0;
   logic [31:0] offset_q = '0;

   // Slots written so far by the queued stimulus, used to keep the search
   // away from memory that has never been written.
   bit [SLOTS-1:0] written_mask = '0;
   int             n_queued     = 0;

   int               n_sent      = 0;
   int               n_seen      = 0;
   int               err_count   = 0;
   int               burst_left  = 0;
   int               gap_left    = 0;
   int               stall_left  = 0;
   int               cycle_count = 0;
   exch_word_type    cur_word;
   pending_word_type cur_pend;

   round_trip_clock_offset_sync_top #(
      .ROUNDS (SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected response for one word; updates the predictor state.
   function automatic sync_result_type predict_sync(exch_word_type w);
      sync_result_type r;
      logic [31:0]     best;
      logic [31:0]     span;
      logic            par;
      int              bi;
      r = '0;
      if (w.kind == KIND_START) begin
         rnd_cnt       = '0;
         adopt_q       = (w.my_count > w.remote_count) ? 1'b0 : 1'b1;
         ts_mem[0]     = w.local_time + offset_q;
         r.send        = 1'b1;
         r.stamp_time  = ts_mem[0];
         r.stamp_adopt = ~adopt_q;
      end else if (w.rx_round >= SLOTS) begin
         r.bad = 1'b1;
      end else begin
         ts_mem[w.rx_round] = w.rx_time;
         adopt_q            = w.rx_adopt;
         rnd_cnt            = 6'(w.rx_round + 1);
         if (rnd_cnt < SLOTS) begin
            ts_mem[rnd_cnt] = w.local_time + offset_q;
            r.send          = 1'b1;
            r.stamp_time    = ts_mem[rnd_cnt];
            r.stamp_round   = 8'(rnd_cnt);
            r.stamp_adopt   = ~adopt_q;
         end
         par = rnd_cnt[0];
         if (rnd_cnt + par >= SLOTS) begin
            r.done = 1'b1;
            if (adopt_q) begin
               // Smallest two-round interval over the slots of this parity.
               best = SPAN_ALL_ONES;
               bi   = par;
               for (int i = par; i + 2 < SLOTS; i += 2) begin
                  span = ts_mem[i+2] - ts_mem[i];
                  if (span < best) begin
                     best = span;
                     bi   = i;
                  end
               end
               offset_q  = offset_q + (ts_mem[bi+1] - (ts_mem[bi] + (best >> 1)));
               r.updated = 1'b1;
            end
         end
      end
      r.offset = offset_q;
      return r;
   endfunction

   // Request tdata for one word.
   function automatic logic [REQ_DATA_W-1:0] pack_req(exch_word_type w);
      logic [REQ_DATA_W-1:0] d;
      d                          = '0;
      d[REQ_LOCAL_LSB +: 32]     = w.local_time;
      d[REQ_MY_LSB +: 16]        = w.my_count;
      d[REQ_REMOTE_LSB +: 16]    = w.remote_count;
      d[REQ_ROUND_LSB +: 8]      = w.rx_round;
      d[REQ_RXTIME_LSB +: 32]    = w.rx_time;
      d[REQ_ADOPT_BIT]           = w.rx_adopt;
      return d;
   endfunction

   // Slots that the interval search reads for a given parity.
   function automatic bit [SLOTS-1:0] slots_read(int par);
      bit [SLOTS-1:0] m;
      m = '0;
      for (int i = par; i + 2 < SLOTS; i += 2) begin
         m[i]   = 1'b1;
         m[i+1] = 1'b1;
         m[i+2] = 1'b1;
      end
      return m;
   endfunction

   // Queue one word. A completing stamp that would search unwritten slots has
   // its adopt flag cleared so that no search takes place.
   task automatic queue_word(logic kind, logic [31:0] lt, logic [15:0] my, logic [15:0] rem,
                             logic [7:0] rr, logic [31:0] rt, logic ra, bit drain);
      pending_word_type p;
      int               rc;
      if (kind == KIND_START) begin
         written_mask[0] = 1'b1;
      end else if (rr < SLOTS) begin
         written_mask[rr] = 1'b1;
         rc = rr + 1;
         if (rc < SLOTS) begin
            written_mask[rc] = 1'b1;
         end
         if (rc + (rc % 2) >= SLOTS && ra &&
             (slots_read(rc % 2) & ~written_mask) != '0) begin
            ra = 1'b0;
         end
      end
      p.w     = '{kind, lt, my, rem, rr, rt, ra};
      p.drain = drain;
      pending.push_back(p);
      n_queued++;
   endtask

   // Report one field mismatch; only the first ten are printed.
   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         err_count++;
         if (err_count <= 10) begin
            $display("response %0d: %s expected %h, got %h", n_seen, name, want, got);
         end
      end
   endtask

   // Driver: presents queued words in bursts with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sync_expected.push_back(predict_sync(cur_word));
            n_sent <= n_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending.size() != 0 &&
                         (!pending[0].drain ||
                          (n_sent == n_seen && !(req_tvalid && req_tready)))) begin
               cur_pend    = pending.pop_front();
               cur_word    = cur_pend.w;
               req_tvalid <= 1'b1;
               req_tuser  <= cur_word.kind;
               req_tdata  <= pack_req(cur_word);
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response word against the oldest prediction and
   // stalls the response stream in stretches of its own.
   always @(posedge clock) begin
      sync_result_type got;
      sync_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.send        = rsp_tdata[RSP_SEND_BIT];
            got.stamp_time  = rsp_tdata[RSP_TIME_LSB +: 32];
            got.stamp_round = rsp_tdata[RSP_ROUND_LSB +: 8];
            got.stamp_adopt = rsp_tdata[RSP_ADOPT_BIT];
            got.done        = rsp_tdata[RSP_DONE_BIT];
            got.updated     = rsp_tdata[RSP_UPD_BIT];
            got.offset      = rsp_tdata[RSP_OFFSET_LSB +: 32];
            got.bad         = rsp_tdata[RSP_BAD_BIT];
            if (sync_expected.size() == 0) begin
               err_count++;
               if (err_count <= 10) begin
                  $display("response %0d arrived with none expected: %h", n_seen, rsp_tdata);
               end
            end else begin
               want = sync_expected.pop_front();
               compare_field("send_stamp", 32'(want.send), 32'(got.send));
               compare_field("stamp_time", want.stamp_time, got.stamp_time);
               compare_field("stamp_round", 32'(want.stamp_round), 32'(got.stamp_round));
               compare_field("stamp_adopt", 32'(want.stamp_adopt), 32'(got.stamp_adopt));
               compare_field("sync_done", 32'(want.done), 32'(got.done));
               compare_field("offset_updated", 32'(want.updated), 32'(got.updated));
               compare_field("clock_offset", want.offset, got.offset);
               compare_field("bad_round", 32'(want.bad), 32'(got.bad));
            end
            n_seen <= n_seen + 1;
         end
         // Quiet stretch while cycle_count[10:9] is zero, a quarter of each window, stalls elsewhere.
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (cycle_count[10:9] != 2'd0 && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [31:0] base;
      logic [31:0] step;
      logic [15:0] my_n;
      logic        adopt_pick;
      int          first;
      int          rr;
      int          target;
      int          next_hold;
      bit          hold;

      for (int i = 0; i < SLOTS; i++) begin
         ts_mem[i] = '0;
      end

      // Stamp before any start, then rounds out of range.
      queue_word(KIND_STAMP, 32'd0, 16'd0, 16'd0, 8'd3, 32'd0, 1'b0, 1'b0);
      queue_word(KIND_STAMP, 32'd5, 16'd0, 16'd0, 8'(SLOTS), 32'd7, 1'b1, 1'b0);
      queue_word(KIND_STAMP, '1, '1, '1, '1, '1, 1'b1, 1'b0);
      // Starts: local count above, below and equal to the remote count.
      queue_word(KIND_START, '1, 16'hFFFF, 16'h0000, '1, '1, 1'b1, 1'b0);
      queue_word(KIND_START, 32'd0, 16'h0000, 16'hFFFF, 8'd0, 32'd0, 1'b0, 1'b0);
      queue_word(KIND_START, 32'd100, 16'h1234, 16'h1234, 8'd0, 32'd0, 1'b0, 1'b0);
      // Initiator exchange with falling local times: every interval is all
      // ones, so the first slot of the parity wins the search.
      queue_word(KIND_STAMP, 32'd99, 16'd0, 16'd0, 8'd1, 32'h0123_4567, 1'b1, 1'b0);
      queue_word(KIND_STAMP, 32'd98, 16'd0, 16'd0, 8'd3, 32'h89AB_CDEF, 1'b1, 1'b0);
      queue_word(KIND_STAMP, 32'd97, 16'd0, 16'd0, 8'd5, 32'h7FFF_FFFF, 1'b1, 1'b0);
      queue_word(KIND_STAMP, 32'd0, 16'd0, 16'd0, 8'd7, 32'h8000_0000, 1'b1, 1'b0);
      // Responder exchange with peer times at the extremes.
      queue_word(KIND_STAMP, 32'hFFFF_FF00, 16'd0, 16'd0, 8'd0, '1, 1'b1, 1'b0);
      queue_word(KIND_STAMP, 32'hFFFF_FFF0, 16'd0, 16'd0, 8'd2, 32'd0, 1'b1, 1'b0);
      queue_word(KIND_STAMP, 32'h0000_0010, 16'd0, 16'd0, 8'd4, 32'd1, 1'b1, 1'b0);
      queue_word(KIND_STAMP, 32'h0000_2000, 16'd0, 16'd0, 8'd6, 32'hFFFF_FFFE, 1'b1, 1'b0);
      // Completion without adopt, then a stamp after completion.
      queue_word(KIND_STAMP, 32'h1000_0000, 16'd0, 16'd0, 8'd7, 32'h5555_5555, 1'b0, 1'b0);
      queue_word(KIND_STAMP, 32'h2000_0000, 16'd0, 16'd0, 8'd7, 32'hAAAA_AAAA, 1'b1, 1'b0);

      // Random part: mostly well-formed exchanges with random content, the
      // rest truncated or out-of-order sequences and noise words.
      target    = n_queued + RANDOM_WORDS;
      next_hold = n_queued;
      while (n_queued < target) begin
         hold = (n_queued >= next_hold);
         if (hold) begin
            next_hold = n_queued + 160;
         end
         if ($urandom_range(0, 9) < 8) begin
            base       = $urandom;
            adopt_pick = ($urandom_range(0, 3) != 0);
            first      = $urandom_range(0, 1);
            if (first == 1 || $urandom_range(0, 3) == 0) begin
               my_n = 16'($urandom);
               queue_word(KIND_START, base, my_n,
                          ($urandom_range(0, 3) == 0) ? my_n : 16'($urandom),
                          8'($urandom), $urandom, 1'($urandom), hold);
               hold = 1'b0;
            end
            for (int r = first; r < SLOTS; r += 2) begin
               if ($urandom_range(0, 24) == 0) begin
                  break;
               end
               if ($urandom_range(0, 4) == 0) begin
                  step = 32'd0;
               end else if ($urandom_range(0, 9) == 0) begin
                  step = $urandom;
               end else begin
                  step = $urandom_range(1, 200000);
               end
               base = base + step;
               rr   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, SLOTS - 1) : r;
               queue_word(KIND_STAMP, base, 16'($urandom), 16'($urandom), 8'(rr), $urandom,
                          ($urandom_range(0, 9) == 0) ? ~adopt_pick : adopt_pick, hold);
               hold = 1'b0;
            end
         end else begin
            queue_word(1'($urandom), $urandom, 16'($urandom), 16'($urandom),
                       ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, SLOTS - 1)),
                       $urandom, 1'($urandom), hold);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid || n_seen < n_sent) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_count == 0 && sync_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
